// ===== src/multi_timer_bank_with_expiry_scan_macros.svh =====
// Assertion macros for the timer bank.
// Used by the top level; relies on signals named clock and reset in scope.
`ifndef MULTI_TIMER_BANK_WITH_EXPIRY_SCAN_MACROS_SVH
`define MULTI_TIMER_BANK_WITH_EXPIRY_SCAN_MACROS_SVH
`ifndef SYNTHESIS
`define MTB_CHECK(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("timer bank check failed");
`define MTB_CHECK_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("timer bank check failed");
`else
`define MTB_CHECK(label, prop)
`define MTB_CHECK_ALWAYS(label, prop)
`endif
`endif

// ===== src/mtb_pkg.sv =====
// Types and constants of the timer bank.
// No dependencies; imported by every module of the block.
`default_nettype none
package mtb_pkg;

   localparam int TIME_BITS  = 16;
   localparam int OWNER_BITS = 4;
   localparam int SLOT_BITS  = 3;
   localparam int FUNC_BITS  = 3;
   localparam int KIND_BITS  = 2;
   localparam int COUNT_BITS = 4;
   localparam int FIRE_BITS  = 16;

   localparam logic [FUNC_BITS-1:0] FN_SET_CB  = 3'd0;
   localparam logic [FUNC_BITS-1:0] FN_SET_EV  = 3'd1;
   localparam logic [FUNC_BITS-1:0] FN_RESET   = 3'd2;
   localparam logic [FUNC_BITS-1:0] FN_RESTART = 3'd3;
   localparam logic [FUNC_BITS-1:0] FN_STOP    = 3'd4;
   localparam logic [FUNC_BITS-1:0] FN_POLL    = 3'd5;
   localparam logic [FUNC_BITS-1:0] FN_QUERY   = 3'd6;
   localparam logic [FUNC_BITS-1:0] FN_EXIT    = 3'd7;

   localparam logic [KIND_BITS-1:0] KIND_EXPIRE = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_ACK    = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_QUERY  = 2'd2;

   typedef struct packed {
      logic [FUNC_BITS-1:0]  func;
      logic [SLOT_BITS-1:0]  slot;
      logic [TIME_BITS-1:0]  now;
      logic [TIME_BITS-1:0]  ticks;
      logic [OWNER_BITS-1:0] owner_id;
   } mtb_req_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]  kind;
      logic [SLOT_BITS-1:0]  fired_slot;
      logic                  fired_mode;
      logic [OWNER_BITS-1:0] fired_owner;
      logic                  is_active;
      logic [TIME_BITS-1:0]  remaining;
      logic [TIME_BITS-1:0]  expiry_time;
      logic [COUNT_BITS-1:0] pending_count;
      logic [TIME_BITS-1:0]  next_expiry;
      logic [FIRE_BITS-1:0]  fires_total;
      logic                  last;
   } mtb_rsp_type;

   // One list entry as held by a cell of the chain.
   typedef struct packed {
      logic [SLOT_BITS-1:0]  slot;
      logic [TIME_BITS-1:0]  start_time;
      logic [TIME_BITS-1:0]  interval_len;
      logic                  mode;
      logic [OWNER_BITS-1:0] owner;
   } mtb_entry_type;

   typedef enum logic [1:0] {
      CH_HOLD = 2'd0,
      CH_KEEP = 2'd1,
      CH_DROP = 2'd2,
      CH_PUSH = 2'd3
   } mtb_chop_type;

   typedef struct packed {
      mtb_chop_type  op;
      mtb_entry_type new_entry;
   } mtb_ctrl_type;

endpackage
`default_nettype wire

// ===== src/mtb_cell.sv =====
// One cell of the arming-order chain: holds a single list entry.
// Depends on mtb_pkg.
`default_nettype none
module mtb_cell import mtb_pkg::*; (
   input  wire logic          clock,
   input  wire mtb_chop_type  op,
   input  wire logic          is_tail,
   input  wire mtb_entry_type from_left,
   input  wire mtb_entry_type from_right,
   input  wire mtb_entry_type from_head,
   output mtb_entry_type      entry
);

   mtb_entry_type entry_ff;
   mtb_entry_type entry_in;

   always_comb begin
      case (op)
         CH_KEEP: entry_in = is_tail ? from_head : from_right;
         CH_DROP: entry_in = from_right;
         CH_PUSH: entry_in = from_left;
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule
`default_nettype wire

// ===== src/mtb_chain.sv =====
// Row of list cells; position 0 is the most recently armed timer.
// Depends on mtb_pkg and mtb_cell.
`default_nettype none
module mtb_chain import mtb_pkg::*; #(
   parameter int NUM_TIMERS = 8,
   parameter int IDX_W      = 3
) (
   input  wire logic             clock,
   input  wire mtb_ctrl_type     ctrl,
   input  wire logic [IDX_W-1:0] tail_pos,
   output mtb_entry_type         head
);

   mtb_entry_type cell_q [NUM_TIMERS];

   for (genvar j = 0; j < NUM_TIMERS; j++) begin : g_cell
      mtb_entry_type left_w;
      mtb_entry_type right_w;

      if (j == 0) begin : g_first
         assign left_w = ctrl.new_entry;
      end else begin : g_mid_l
         assign left_w = cell_q[j-1];
      end

      if (j == NUM_TIMERS - 1) begin : g_last
         assign right_w = cell_q[j];
      end else begin : g_mid_r
         assign right_w = cell_q[j+1];
      end

      mtb_cell u_cell (
         .clock      (clock),
         .op         (ctrl.op),
         .is_tail    (tail_pos == IDX_W'(j)),
         .from_left  (left_w),
         .from_right (right_w),
         .from_head  (cell_q[0]),
         .entry      (cell_q[j])
      );
   end

   assign head = cell_q[0];

endmodule
`default_nettype wire

// ===== src/multi_timer_bank_with_expiry_scan.sv =====
// Bank of one-shot timers with an expiry scan; depends on mtb_pkg, mtb_chain and the
// assertion macro header. Armed timers sit in a chain of cells in arming order, newest at
// the head. Each item walks the live list once, over the timers armed when it is accepted:
// the head cell is examined every cycle that the result side does not stall and is either
// dropped (the chain closes up) or rotated to the tail of the live list, so order is kept.
// Set, reset and restart then push the slot onto the head. Poll gives one item per expired
// timer, in list order, with last on the final one, or a single item if none has expired;
// every other command gives exactly one item. No clearing pass is needed after reset.
`default_nettype none
`include "multi_timer_bank_with_expiry_scan_macros.svh"
module multi_timer_bank_with_expiry_scan import mtb_pkg::*; #(
   parameter int NUM_TIMERS = 8
) (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  req_valid,
   output logic       req_stall,
   input  wire mtb_req_type req_item,
   output logic       rsp_valid,
   input  wire logic  rsp_stall,
   output mtb_rsp_type rsp_item
);

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CNT_W = $clog2(NUM_TIMERS + 1);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_WALK   = 4'b0010,
      S_PUSH   = 4'b0100,
      S_FINISH = 4'b1000
   } mtb_state_type;

   mtb_state_type state_ff, state_in;
   mtb_req_type   req_ff, req_in;
   logic [CNT_W-1:0] steps_ff, steps_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic [FIRE_BITS-1:0] fires_ff, fires_in;
   mtb_rsp_type   pend_ff, pend_in;
   logic          pend_valid_ff, pend_valid_in;
   logic [TIME_BITS-1:0] best_ff, best_in;
   logic [TIME_BITS-1:0] dist_ff, dist_in;
   logic          have_best_ff, have_best_in;
   mtb_rsp_type   rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Per-slot record; survives stop and expiry so that reset and restart can re-arm.
   logic [TIME_BITS-1:0]  start_ff [NUM_TIMERS];
   logic [TIME_BITS-1:0]  intv_ff  [NUM_TIMERS];
   logic                  mode_ff  [NUM_TIMERS];
   logic [OWNER_BITS-1:0] owner_ff [NUM_TIMERS];
   logic                  armed_ff [NUM_TIMERS];

   mtb_ctrl_type  ch_ctrl;
   mtb_entry_type head;
   mtb_entry_type new_entry;

   logic             slot_ok;
   logic [IDX_W-1:0] slot_idx;
   logic [IDX_W-1:0] head_idx;
   logic             is_arm;
   logic             is_set;
   logic             head_drop;
   logic [TIME_BITS-1:0] head_elapsed;
   logic [TIME_BITS-1:0] head_exp;
   logic [TIME_BITS-1:0] head_dist;
   logic [TIME_BITS-1:0] q_elapsed;
   logic [TIME_BITS-1:0] q_rem;
   logic             out_free;
   logic             drop_en;
   logic             arm_en;
   mtb_rsp_type      ack_rsp;
   mtb_rsp_type      final_rsp;

   assign slot_ok  = 32'(req_ff.slot) < NUM_TIMERS;
   assign slot_idx = IDX_W'(req_ff.slot);
   assign head_idx = IDX_W'(head.slot);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign is_set   = (req_ff.func == FN_SET_CB) || (req_ff.func == FN_SET_EV);
   assign is_arm   = is_set || (req_ff.func == FN_RESET) || (req_ff.func == FN_RESTART);

   // Head cell tests: due check, expiry time and distance from now, all wrapping.
   assign head_elapsed = req_ff.now - head.start_time;
   assign head_exp     = head.start_time + head.interval_len;
   assign head_dist    = head_exp - req_ff.now;

   always_comb begin
      unique case (req_ff.func) inside
         FN_POLL:                                    head_drop = head_elapsed >= head.interval_len;
         FN_EXIT:                                    head_drop = head.owner == req_ff.owner_id;
         FN_SET_CB, FN_SET_EV, FN_RESET, FN_RESTART,
         FN_STOP:                                    head_drop = slot_ok && (head.slot == req_ff.slot);
         default:                                    head_drop = 1'b0;
      endcase
   end

   // Entry pushed onto the head when a slot is armed.
   always_comb begin
      new_entry.slot = req_ff.slot;
      if (req_ff.func == FN_RESET) begin
         new_entry.start_time = start_ff[slot_idx] + intv_ff[slot_idx];
      end else begin
         new_entry.start_time = req_ff.now;
      end
      new_entry.interval_len = is_set ? req_ff.ticks : intv_ff[slot_idx];
      new_entry.mode         = is_set ? req_ff.func[0] : mode_ff[slot_idx];
      new_entry.owner        = is_set ? req_ff.owner_id : owner_ff[slot_idx];
   end

   // Closing results.
   assign q_elapsed = req_ff.now - start_ff[slot_idx];
   assign q_rem     = (armed_ff[slot_idx] && (q_elapsed < intv_ff[slot_idx])) ?
                      intv_ff[slot_idx] - q_elapsed : '0;

   always_comb begin
      ack_rsp               = '0;
      ack_rsp.kind          = KIND_ACK;
      ack_rsp.fired_slot    = req_ff.slot;
      ack_rsp.pending_count = COUNT_BITS'(len_ff);
      ack_rsp.fires_total   = fires_ff;
      ack_rsp.last          = 1'b1;
      if (slot_ok) begin
         ack_rsp.fired_mode  = mode_ff[slot_idx];
         ack_rsp.fired_owner = owner_ff[slot_idx];
         ack_rsp.is_active   = armed_ff[slot_idx];
      end

      final_rsp = ack_rsp;
      if (req_ff.func == FN_POLL) begin
         if (pend_valid_ff) begin
            final_rsp      = pend_ff;
            final_rsp.last = 1'b1;
         end else begin
            final_rsp.fired_slot  = '0;
            final_rsp.fired_mode  = 1'b0;
            final_rsp.fired_owner = '0;
            final_rsp.is_active   = 1'b0;
         end
      end else if (req_ff.func == FN_QUERY) begin
         final_rsp.kind        = KIND_QUERY;
         final_rsp.next_expiry = have_best_ff ? best_ff : '0;
         if (slot_ok) begin
            final_rsp.remaining   = q_rem;
            final_rsp.expiry_time = start_ff[slot_idx] + intv_ff[slot_idx];
         end
      end
   end

   // Sequencer: capture, walk the chain, push, deliver.
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      steps_in      = steps_ff;
      len_in        = len_ff;
      fires_in      = fires_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      best_in       = best_ff;
      dist_in       = dist_ff;
      have_best_in  = have_best_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      ch_ctrl.op        = CH_HOLD;
      ch_ctrl.new_entry = new_entry;
      drop_en       = 1'b0;
      arm_en        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in        = req_item;
               steps_in      = len_ff;
               pend_valid_in = 1'b0;
               have_best_in  = 1'b0;
               state_in      = S_WALK;
            end
         end
         S_WALK: begin
            if (steps_ff == '0) begin
               state_in = (is_arm && slot_ok) ? S_PUSH : S_FINISH;
            end else if (out_free) begin
               steps_in = steps_ff - CNT_W'(1);
               if (head_drop) begin
                  ch_ctrl.op = CH_DROP;
                  len_in     = len_ff - CNT_W'(1);
                  drop_en    = 1'b1;
                  if (req_ff.func == FN_POLL) begin
                     fires_in = fires_ff + FIRE_BITS'(1);
                     // Release the previous expiry; hold this one until it is known
                     // whether another follows.
                     if (pend_valid_ff) begin
                        rsp_in       = pend_ff;
                        rsp_valid_in = 1'b1;
                     end
                     pend_in               = '0;
                     pend_in.kind          = KIND_EXPIRE;
                     pend_in.fired_slot    = head.slot;
                     pend_in.fired_mode    = head.mode;
                     pend_in.fired_owner   = head.owner;
                     pend_in.pending_count = COUNT_BITS'(len_ff - CNT_W'(1));
                     pend_in.fires_total   = fires_ff + FIRE_BITS'(1);
                     pend_valid_in         = 1'b1;
                  end
               end else begin
                  ch_ctrl.op = CH_KEEP;
                  // Strict compare: ties stay with the entry met first in the walk.
                  if ((req_ff.func == FN_QUERY) && (!have_best_ff || (head_dist < dist_ff))) begin
                     best_in      = head_exp;
                     dist_in      = head_dist;
                     have_best_in = 1'b1;
                  end
               end
            end
         end
         S_PUSH: begin
            ch_ctrl.op = CH_PUSH;
            len_in     = len_ff + CNT_W'(1);
            arm_en     = 1'b1;
            state_in   = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_in       = final_rsp;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         len_ff        <= '0;
         fires_ff      <= '0;
         pend_valid_ff <= 1'b0;
         have_best_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         steps_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         len_ff        <= len_in;
         fires_ff      <= fires_in;
         pend_valid_ff <= pend_valid_in;
         have_best_ff  <= have_best_in;
         rsp_valid_ff  <= rsp_valid_in;
         steps_ff      <= steps_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      pend_ff <= pend_in;
      best_ff <= best_in;
      dist_ff <= dist_in;
      rsp_ff  <= rsp_in;
   end

   // Slot records: arm writes the addressed slot, a drop clears the head slot's armed bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_TIMERS; k++) begin
            start_ff[k] <= '0;
            intv_ff[k]  <= '0;
            mode_ff[k]  <= 1'b0;
            owner_ff[k] <= '0;
            armed_ff[k] <= 1'b0;
         end
      end else if (arm_en) begin
         start_ff[slot_idx] <= new_entry.start_time;
         intv_ff[slot_idx]  <= new_entry.interval_len;
         mode_ff[slot_idx]  <= new_entry.mode;
         owner_ff[slot_idx] <= new_entry.owner;
         armed_ff[slot_idx] <= 1'b1;
      end else if (drop_en) begin
         armed_ff[head_idx] <= 1'b0;
      end
   end

   mtb_chain #(
      .NUM_TIMERS (NUM_TIMERS),
      .IDX_W      (IDX_W)
   ) u_chain (
      .clock    (clock),
      .ctrl     (ch_ctrl),
      .tail_pos (IDX_W'(len_ff - CNT_W'(1))),
      .head     (head)
   );

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `MTB_CHECK(len_in_range_a, len_ff <= CNT_W'(NUM_TIMERS))
   `MTB_CHECK(pend_only_in_poll_a, pend_valid_ff |-> (req_ff.func == FN_POLL))
   `MTB_CHECK(push_has_room_a, (ch_ctrl.op == CH_PUSH) |-> (len_ff < CNT_W'(NUM_TIMERS)))

endmodule
`default_nettype wire
